// ===== design/tcw_pkg.sv =====
// shared types and constants of the text console writer
// no dependencies; used by every module of the block but tcw_ram
`default_nettype none

package tcw_pkg;

    // request function codes
    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // character codes and the reset fill attribute
    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'd32;
    localparam logic [7:0] FILL_RESET   = 8'h0F;

    // one cell: attribute in the high byte, character in the low byte
    localparam int CELL_W = 16;

    // cell store write source
    localparam logic [1:0] WR_NONE  = 2'd0;
    localparam logic [1:0] WR_CHAR  = 2'd1;
    localparam logic [1:0] WR_BLANK = 2'd2;
    localparam logic [1:0] WR_COPY  = 2'd3;

    // cell store read address source
    localparam logic [1:0] RD_IDX        = 2'd0;
    localparam logic [1:0] RD_AHEAD      = 2'd1;
    localparam logic [1:0] RD_AHEAD_NEXT = 2'd2;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  char_code;
        logic [7:0]  color;
        logic [10:0] cell_index;
    } in_item_t;

    typedef struct packed {
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic [7:0] read_char;
        logic [7:0] read_attr;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic       latch_item;
        logic [1:0] wr_sel;
        logic       blank_reset;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       cnt_clr;
        logic       cnt_inc;
        logic       cursor_put;
        logic       cursor_home;
        logic       rd_clear;
        logic       rd_capture;
        logic       out_load;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] func;
        logic       is_newline;
        logic       scroll_needed;
        logic       cnt_last_fill;
        logic       cnt_last_copy;
        logic       out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

// ===== design/tcw_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/tcw_ctrl.sv =====
// controller state machine of the text console writer
// depends on tcw_pkg for command and status structs and codes
`default_nettype none

module tcw_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire tcw_pkg::dp_sts_t sts,
    output tcw_pkg::ctl_cmd_t     cmd
);

    import tcw_pkg::*;

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_EXEC  = 4'd2;
    localparam logic [3:0] S_READ  = 4'd3;
    localparam logic [3:0] S_CLEAR = 4'd4;
    localparam logic [3:0] S_SCR0  = 4'd5;
    localparam logic [3:0] S_SCR1  = 4'd6;
    localparam logic [3:0] S_BLANK = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // requests are taken only when nothing is in progress
    assign in_stall = (state_reg != S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.wr_sel = WR_NONE;
        cmd.rd_sel = RD_IDX;
        case (state_reg)
            S_INIT:
            begin
                cmd.wr_sel      = WR_BLANK;
                cmd.blank_reset = 1'b1;
                cmd.cnt_inc     = 1'b1;
                if (sts.cnt_last_fill)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_item = 1'b1;
                    state_next     = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.cnt_clr = 1'b1;
                case (sts.func)
                    FUNC_PUT:
                    begin
                        cmd.wr_sel     = sts.is_newline ? WR_NONE : WR_CHAR;
                        cmd.cursor_put = 1'b1;
                        cmd.rd_clear   = 1'b1;
                        state_next     = sts.scroll_needed ? S_SCR0 : S_DONE;
                    end
                    FUNC_CLEAR:
                    begin
                        cmd.cursor_home = 1'b1;
                        cmd.rd_clear    = 1'b1;
                        state_next      = S_CLEAR;
                    end
                    FUNC_READ:
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_IDX;
                        state_next = S_READ;
                    end
                    default:
                    begin
                        cmd.rd_clear = 1'b1;
                        state_next   = S_DONE;
                    end
                endcase
            end
            S_READ:
            begin
                cmd.rd_capture = 1'b1;
                state_next     = S_DONE;
            end
            S_CLEAR:
            begin
                cmd.wr_sel  = WR_BLANK;
                cmd.cnt_inc = 1'b1;
                if (sts.cnt_last_fill)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_SCR0:
            begin
                // prime the copy: fetch the first cell of the second row
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_AHEAD;
                state_next = S_SCR1;
            end
            S_SCR1:
            begin
                cmd.wr_sel  = WR_COPY;
                cmd.cnt_inc = 1'b1;
                if (sts.cnt_last_copy)
                begin
                    state_next = S_BLANK;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_AHEAD_NEXT;
                end
            end
            S_BLANK:
            begin
                cmd.wr_sel  = WR_BLANK;
                cmd.cnt_inc = 1'b1;
                if (sts.cnt_last_fill)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/tcw_datapath.sv =====
// datapath of the text console writer: cursor, sweep counter, cell store, output register
// depends on tcw_pkg and tcw_ram
`default_nettype none

module tcw_datapath #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tcw_pkg::in_item_t in_data,
    input  wire logic              cfg_we,
    input  wire logic [7:0]        cfg_wdata,
    input  wire logic              out_stall,
    output logic                   out_valid,
    output tcw_pkg::out_item_t     out_data,
    input  wire tcw_pkg::ctl_cmd_t cmd,
    output tcw_pkg::dp_sts_t       sts
);

    import tcw_pkg::*;

    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam logic [ADDR_W-1:0] COLS_A      = ADDR_W'(COLS);
    localparam logic [ADDR_W-1:0] ONE_A       = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] LAST_FILL_A = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_COPY_A = ADDR_W'(CELLS - COLS - 1);

    in_item_t          item_reg;
    logic [6:0]        col_reg;
    logic [6:0]        col_next;
    logic [4:0]        row_reg;
    logic [4:0]        row_next;
    logic [ADDR_W-1:0] cnt_reg;
    logic [ADDR_W-1:0] cnt_next;
    logic [7:0]        fill_reg;
    logic [7:0]        rd_char_reg;
    logic [7:0]        rd_attr_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_item_t         out_data_reg;

    logic [7:0]        col_inc;
    logic [5:0]        row_inc;
    logic              wrap;
    logic              scroll;
    logic              idx_in_range;
    logic [12:0]       idx_wide;
    logic [ADDR_W-1:0] pos;
    logic [CELL_W-1:0] blank_cell;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    // latched request
    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            item_reg <= in_data;
        end
    end

    // cursor advance for a put
    assign col_inc = {1'b0, col_reg} + 8'd1;
    assign row_inc = {1'b0, row_reg} + 6'd1;
    assign wrap    = (item_reg.char_code == NEWLINE_CODE) || (32'(col_inc) >= COLS);
    assign scroll  = wrap && (32'(row_inc) >= ROWS);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.cursor_home)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (cmd.cursor_put)
        begin
            if (wrap)
            begin
                col_next = '0;
                row_next = scroll ? 5'(ROWS - 1) : row_inc[4:0];
            end
            else
            begin
                col_next = col_inc[6:0];
            end
        end
    end

    // cursor, sweep counter, fill attribute and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
            fill_reg      <= FILL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                fill_reg <= cfg_wdata;
            end
        end
    end

    // sweep counter over the cell store
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + ONE_A;
        end
    end

    // cell store addressing and write data
    assign idx_wide     = 13'(item_reg.cell_index);
    assign idx_in_range = (idx_wide < 13'(CELLS));
    assign pos          = ADDR_W'(32'(row_reg) * COLS + 32'(col_reg));
    assign blank_cell   = {(cmd.blank_reset ? FILL_RESET : fill_reg), SPACE_CODE};

    always_comb
    begin
        ram_we    = 1'b1;
        ram_waddr = cnt_reg;
        ram_wdata = blank_cell;
        case (cmd.wr_sel)
            WR_CHAR:
            begin
                ram_waddr = pos;
                ram_wdata = {item_reg.color, item_reg.char_code};
            end
            WR_BLANK:
            begin
                ram_wdata = blank_cell;
            end
            WR_COPY:
            begin
                ram_wdata = ram_rdata;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.rd_sel)
            RD_AHEAD:      ram_raddr = cnt_reg + COLS_A;
            RD_AHEAD_NEXT: ram_raddr = cnt_reg + COLS_A + ONE_A;
            default:       ram_raddr = idx_wide[ADDR_W-1:0];
        endcase
    end

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // read result, zero for anything but an in-range read
    always_ff @(posedge clk)
    begin
        if (cmd.rd_clear)
        begin
            rd_char_reg <= '0;
            rd_attr_reg <= '0;
        end
        else if (cmd.rd_capture)
        begin
            rd_char_reg <= idx_in_range ? ram_rdata[7:0] : 8'd0;
            rd_attr_reg <= idx_in_range ? ram_rdata[15:8] : 8'd0;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg.cursor_col <= col_reg;
            out_data_reg.cursor_row <= row_reg;
            out_data_reg.read_char  <= rd_char_reg;
            out_data_reg.read_attr  <= rd_attr_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // status to the controller
    assign sts.func          = item_reg.func;
    assign sts.is_newline    = (item_reg.char_code == NEWLINE_CODE);
    assign sts.scroll_needed = scroll;
    assign sts.cnt_last_fill = (cnt_reg == LAST_FILL_A);
    assign sts.cnt_last_copy = (cnt_reg == LAST_COPY_A);
    assign sts.out_free      = !out_valid_reg || !out_stall;

endmodule

`default_nettype wire

// ===== design/text_console_writer_unit.sv =====
// Text console writer: a ROWS x COLS store of character/attribute cells and a
// cursor. Each request (put, clear, read) gives one result with the cursor
// after it and, for a read, the cell. A put that scrolls and a clear take
// longer than other requests, set by the single write port of the cell store,
// which is walked one cell a cycle. After reset a clearing pass over all
// ROWS*COLS cells (2000 by default) fills the store before the first request
// is taken; configuration writes are accepted at any time. Depends on tcw_pkg,
// tcw_ctrl and tcw_datapath.
`default_nettype none

module text_console_writer_unit #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire tcw_pkg::in_item_t in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output tcw_pkg::out_item_t     out_data,
    input  wire logic              cfg_we,
    input  wire logic [7:0]        cfg_wdata
);

    import tcw_pkg::*;

    ctl_cmd_t cmd;
    dp_sts_t  sts;

    // sequencer
    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // cursor, cell store and result register
    tcw_datapath #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

// ===== design/tcw_checker.sv =====
// port-level checks of the text console writer, bound to the top level
// depends on tcw_pkg and text_console_writer_unit
`default_nettype none

module tcw_checker #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire tcw_pkg::in_item_t  in_data,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire tcw_pkg::out_item_t out_data
);

    import tcw_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // the cursor reported stays on the screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(out_data.cursor_col) < COLS) && (32'(out_data.cursor_row) < ROWS))
        else $error("cursor outside the screen");

    // one request at a time: a taken request closes the input
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken while another was in progress");

    // every request but a read leaves no read data in the result
    a_zero_unless_read: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_data.func != FUNC_READ) |=> ##2
        !out_valid || $stable(out_data) ||
        ((out_data.read_char == 8'd0) && (out_data.read_attr == 8'd0)))
        else $error("read data on a non-read result");

endmodule

bind text_console_writer_unit tcw_checker #(
    .COLS (COLS),
    .ROWS (ROWS)
) u_tcw_checker (.*);

`default_nettype wire

// ===== bench/tb_text_console_writer_unit.sv =====
// self-checking bench for the text console writer: directed and random put, clear and read
// requests, each result checked against a bench-side model of the cell store and cursor
// depends on tcw_pkg and text_console_writer_unit
module tb_text_console_writer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int COLS = 80;
    localparam int ROWS = 25;
    localparam int CELLS = COLS * ROWS;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int HALF_PERIOD = 4;
    localparam int RESET_CYCLES = 12;
    // a scroll or clear walks every cell once; leave plenty of room above that
    localparam int SETTLE_CYCLES = CELLS + 50;
    localparam int QUIET_LIMIT = 20000;
    localparam int MAX_REPORTS = 30;
    localparam int STAGES = 6;
    localparam int RANDOM_PER_STAGE = 275;

    // shadow copy of the console: cells, cursor and fill attribute
    class console_scoreboard;
        logic [15:0] cells [CELLS];
        int unsigned col;
        int unsigned row;
        logic [7:0]  fill;
        out_item_t   awaited [$];
        int unsigned errors;
        int unsigned checked;
        int unsigned scrolls;
        int unsigned clears;

        function new();
            fill = FILL_RESET;
            blank_all();
            col = 0;
            row = 0;
            errors = 0;
            checked = 0;
            scrolls = 0;
            clears = 0;
        endfunction

        function void blank_all();
            for (int i = 0; i < CELLS; i++)
                cells[i] = {fill, SPACE_CODE};
        endfunction

        // apply one accepted request and queue the result it should give
        function void note_request(in_item_t req);
            out_item_t exp;
            exp = '0;
            case (req.func)
                FUNC_PUT:
                begin
                    if (req.char_code == NEWLINE_CODE)
                    begin
                        col = 0;
                        row++;
                    end
                    else
                    begin
                        cells[row * COLS + col] = {req.color, req.char_code};
                        col++;
                    end
                    if (col >= COLS)
                    begin
                        col = 0;
                        row++;
                    end
                    // past the bottom row: shift everything up one row
                    if (row >= ROWS)
                    begin
                        for (int i = 0; i < CELLS - COLS; i++)
                            cells[i] = cells[i + COLS];
                        for (int i = CELLS - COLS; i < CELLS; i++)
                            cells[i] = {fill, SPACE_CODE};
                        row = ROWS - 1;
                        scrolls++;
                    end
                end
                FUNC_CLEAR:
                begin
                    blank_all();
                    col = 0;
                    row = 0;
                    clears++;
                end
                FUNC_READ:
                begin
                    if (req.cell_index < CELLS)
                    begin
                        exp.read_char = cells[req.cell_index][7:0];
                        exp.read_attr = cells[req.cell_index][15:8];
                    end
                end
                default: ;
            endcase
            exp.cursor_col = 7'(col);
            exp.cursor_row = 5'(row);
            awaited.push_back(exp);
        endfunction

        // compare one accepted result with the oldest expectation
        function void check_result(out_item_t got);
            out_item_t exp;
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result col %0d row %0d char %02h attr %02h",
                             $time, got.cursor_col, got.cursor_row, got.read_char,
                             got.read_attr);
                return;
            end
            exp = awaited.pop_front();
            checked++;
            if (got.cursor_col !== exp.cursor_col || got.cursor_row !== exp.cursor_row ||
                got.read_char !== exp.read_char || got.read_attr !== exp.read_attr)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display({"%0t: mismatch expected col %0d row %0d char %02h attr %02h,",
                              " got col %0d row %0d char %02h attr %02h"},
                             $time, exp.cursor_col, exp.cursor_row, exp.read_char,
                             exp.read_attr, got.cursor_col, got.cursor_row, got.read_char,
                             got.read_attr);
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;
    logic      cfg_we = 1'b0;
    logic [7:0] cfg_wdata = '0;

    console_scoreboard board;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned issued = 0;
    int unsigned ignored = 0;
    int unsigned quiet_cycles = 0;

    text_console_writer_unit #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    always #HALF_PERIOD clk = ~clk;

    // result side: check accepted results, stall at the current rate
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                board.check_result(out_data);
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog on cycles with no request and no result moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= QUIET_LIMIT)
            begin
                $display("%0t: nothing moved for %0d cycles", $time, QUIET_LIMIT);
                $display("Verification failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // request with every field random
    function automatic in_item_t any_request(logic [1:0] func);
        in_item_t r;
        r.func = func;
        r.char_code = 8'($urandom);
        r.color = 8'($urandom);
        r.cell_index = 11'($urandom);
        return r;
    endfunction

    // present one request, optionally after an idle gap, and wait for it to be taken
    task automatic send_request(input in_item_t req);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_request(req);
        if (req.func == FUNC_UNUSED)
            ignored++;
        else
            issued++;
    endtask

    // stop sending until every outstanding result is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.awaited.size() != 0)
            @(posedge clk);
    endtask

    // change the fill attribute once the block has gone quiet
    task automatic write_fill(input logic [7:0] value);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.fill = value;
    endtask

    // random text, newlines, reads, clears and noise until the quota is met
    task automatic random_traffic(input int unsigned quota);
        in_item_t req;
        int unsigned target;
        int unsigned pick;
        int unsigned row_sel;
        int unsigned pos;
        target = issued + quota;
        while (issued < target)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                // a line of text, long ones wrap and may scroll
                repeat ($urandom_range(1, 100))
                    send_request(any_request(FUNC_PUT));
                if ($urandom_range(1))
                begin
                    req = any_request(FUNC_PUT);
                    req.char_code = NEWLINE_CODE;
                    send_request(req);
                end
            end
            else if (pick < 72)
            begin
                // reads, mostly around the cursor rows
                repeat ($urandom_range(1, 6))
                begin
                    req = any_request(FUNC_READ);
                    pick = $urandom_range(9);
                    if (pick < 6)
                    begin
                        row_sel = board.row;
                        if (row_sel > 0 && $urandom_range(1))
                            row_sel--;
                        req.cell_index = 11'(row_sel * COLS + $urandom_range(COLS - 1));
                    end
                    else if (pick < 9)
                        req.cell_index = 11'($urandom_range(CELLS - 1));
                    send_request(req);
                end
            end
            else if (pick < 82)
            begin
                // newlines down to the bottom row and a scroll or two beyond it
                repeat (ROWS - 1 - board.row + $urandom_range(1, 2))
                begin
                    req = any_request(FUNC_PUT);
                    req.char_code = NEWLINE_CODE;
                    send_request(req);
                end
            end
            else if (pick < 86)
                send_request(any_request(FUNC_CLEAR));
            else if (pick < 95)
            begin
                repeat ($urandom_range(1, 3))
                    send_request(any_request(FUNC_UNUSED));
            end
            else if (pick < 97)
                drain();
            else
            begin
                // write one cell and read it straight back
                pos = board.row * COLS + board.col;
                send_request(any_request(FUNC_PUT));
                req = any_request(FUNC_READ);
                req.cell_index = 11'(pos);
                send_request(req);
            end
        end
    endtask

    // main sequence
    initial
    begin
        logic [7:0]  fill_plan [STAGES];
        int unsigned send_plan [STAGES];
        int unsigned recv_plan [STAGES];
        fill_plan = '{FILL_RESET, 8'h00, 8'hFF, 8'($urandom), 8'h80, 8'($urandom)};
        send_plan = '{0, 79, 0, 32, 0, 32};
        recv_plan = '{0, 0, 79, 32, 0, 32};
        board = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset contents, range edges, the unused code, newline and clear
        send_request(in_item_t'{FUNC_READ, 8'h00, 8'h00, 11'd0});
        send_request(in_item_t'{FUNC_READ, 8'h00, 8'h00, 11'(CELLS - 1)});
        send_request(in_item_t'{FUNC_READ, 8'hFF, 8'hFF, 11'(CELLS)});
        send_request(in_item_t'{FUNC_READ, 8'h00, 8'h00, 11'h7FF});
        send_request(in_item_t'{FUNC_UNUSED, 8'hFF, 8'hFF, 11'h7FF});
        send_request(in_item_t'{FUNC_PUT, 8'h00, 8'h00, 11'h7FF});
        send_request(in_item_t'{FUNC_PUT, 8'hFF, 8'hFF, 11'd0});
        send_request(in_item_t'{FUNC_PUT, NEWLINE_CODE, 8'hAA, 11'd0});
        send_request(in_item_t'{FUNC_READ, 8'h00, 8'h00, 11'd0});
        send_request(in_item_t'{FUNC_READ, 8'h00, 8'h00, 11'd1});
        send_request(in_item_t'{FUNC_READ, 8'h00, 8'h00, 11'd2});
        send_request(in_item_t'{FUNC_PUT, 8'h41, 8'h1E, 11'd0});
        send_request(in_item_t'{FUNC_READ, 8'h00, 8'h00, 11'(COLS)});
        send_request(in_item_t'{FUNC_CLEAR, 8'h55, 8'h55, 11'h555});
        send_request(in_item_t'{FUNC_READ, 8'h00, 8'h00, 11'd0});
        send_request(in_item_t'{FUNC_READ, 8'h00, 8'h00, 11'(COLS)});

        // random stages, each with its own fill attribute and idle rates
        for (int s = 0; s < STAGES; s++)
        begin
            if (s > 0)
                write_fill(fill_plan[s]);
            send_idle_pct = send_plan[s];
            recv_idle_pct = recv_plan[s];
            random_traffic(RANDOM_PER_STAGE);
        end

        drain();
        recv_idle_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d requests plus %0d with the unused code, %0d clears, %0d scrolls,",
                 issued, ignored, board.clears, board.scrolls);
        $display("%0d results checked over %0d fill settings and idle/stall mixes",
                 board.checked, STAGES);
        if (board.errors == 0 && board.awaited.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== text_console_writer_unit.f =====
design/tcw_pkg.sv
design/tcw_ram.sv
design/tcw_ctrl.sv
design/tcw_datapath.sv
design/text_console_writer_unit.sv
design/tcw_checker.sv
bench/tb_text_console_writer_unit.sv
